/* rtl/core/stream_pattern_removal_stack_defines.svh */
// Assertion macros shared by the pattern removal stack modules.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef STREAM_PATTERN_REMOVAL_STACK_DEFINES_SVH
`define STREAM_PATTERN_REMOVAL_STACK_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define SPR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SPR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/spr_pkg.sv */
package spr_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int KEPT_W   = 11;
    localparam int PAT_W    = 64;
    localparam int PLEN_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top level parameters
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int MAX_PATTERN_DEF = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Opcodes on the input channel
    localparam logic [OPCODE_W-1:0] OPC_PUSH  = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_CLEAR = 2'd2;
    localparam logic [OPCODE_W-1:0] OPC_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] text_byte;
    } t_cmd;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern_bytes;
        logic [PLEN_W-1:0] pattern_length;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [KEPT_W-1:0] kept_count;
        logic              removed;
        logic              read_last;
        logic              read_empty;
        logic              overflow;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_MATCH,
        S_RDADDR,
        S_RDDATA,
        S_DONE
    } t_state;

endpackage

/* rtl/core/stream_pattern_removal_stack.sv */
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_opcode, i_text_byte
// output    out        o_out_valid / i_out_stall o_out_byte, o_kept_count, o_removed,
//                                                o_read_last, o_read_empty, o_overflow
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// In the back end a push makes one stack memory read per pattern character, each
// compared in the cycle after its read. Each command passes the front register
// and the queue on the way in, and its result leaves through the output register.
// Synchronous active-low reset empties the stack at once; no clearing pass.
// An output stall holds the result register; the back end then waits, the
// queue fills and the input stalls. Configuration writes are always ready.
module stream_pattern_removal_stack #(
    parameter int STACK_DEPTH = spr_pkg::STACK_DEPTH_DEF,
    parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spr_pkg::PAT_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [spr_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [spr_pkg::BYTE_W-1:0]     i_text_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [spr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic [spr_pkg::KEPT_W-1:0]     o_kept_count,
    output logic                           o_removed,
    output logic                           o_read_last,
    output logic                           o_read_empty,
    output logic                           o_overflow
);

    spr_pkg::t_cfg    r_cfg;
    spr_pkg::t_cmd    w_front_cmd;
    spr_pkg::t_cmd    w_q_cmd;
    spr_pkg::t_result w_out;
    logic             w_push;
    logic             w_q_full;
    logic             w_q_valid;
    logic             w_q_pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes  <= '0;
            r_cfg.pattern_length <= spr_pkg::PLEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spr_pkg::CFG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= i_cfg_data;
                spr_pkg::CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[spr_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    spr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_text_byte (i_text_byte),
        .o_in_stall  (o_in_stall),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_front_cmd)
    );

    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    spr_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (w_out)
    );

    // Unpack the result onto the output ports
    assign o_out_byte   = w_out.out_byte;
    assign o_kept_count = w_out.kept_count;
    assign o_removed    = w_out.removed;
    assign o_read_last  = w_out.read_last;
    assign o_read_empty = w_out.read_empty;
    assign o_overflow   = w_out.overflow;

endmodule

/* rtl/core/spr_front.sv */
module spr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [spr_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [spr_pkg::BYTE_W-1:0]    i_text_byte,
    output logic                          o_in_stall,
    input  logic                          i_q_full,
    output logic                          o_push,
    output spr_pkg::t_cmd                 o_cmd
);

    logic          r_valid;
    logic          n_valid;
    spr_pkg::t_cmd r_cmd;
    spr_pkg::t_cmd w_cmd;
    logic          w_accept;

    // Classify the opcode into a command
    always_comb begin
        w_cmd.text_byte = i_text_byte;
        unique case (i_opcode)
            spr_pkg::OPC_PUSH:  w_cmd.op = spr_pkg::OP_PUSH;
            spr_pkg::OPC_READ:  w_cmd.op = spr_pkg::OP_READ;
            spr_pkg::OPC_CLEAR: w_cmd.op = spr_pkg::OP_CLEAR;
            default:            w_cmd.op = spr_pkg::OP_NOP;
        endcase
    end

    // Hold the classified command until the queue takes it
    assign o_in_stall = r_valid && i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

/* rtl/core/spr_queue.sv */
`include "stream_pattern_removal_stack_defines.svh"

module spr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output spr_pkg::t_cmd o_cmd
);

    spr_pkg::t_cmd                  r_entry [spr_pkg::QUEUE_DEPTH];
    logic [spr_pkg::QPTR_W-1:0]     r_wptr;
    logic [spr_pkg::QPTR_W-1:0]     r_rptr;
    logic [spr_pkg::QFILL_W-1:0]    r_fill;
    logic [spr_pkg::QPTR_W-1:0]     n_wptr;
    logic [spr_pkg::QPTR_W-1:0]     n_rptr;
    logic [spr_pkg::QFILL_W-1:0]    n_fill;

    assign o_full  = (r_fill == spr_pkg::QFILL_W'(spr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_entry[r_rptr];

    // Advance pointers and fill level
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_push) begin
            n_wptr = r_wptr + spr_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + spr_pkg::QPTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + spr_pkg::QFILL_W'(1);
            2'b01:   n_fill = r_fill - spr_pkg::QFILL_W'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    `SPR_ASSERT_IMPLY(a_push_not_full, i_push, !o_full, "queue written while full")
    `SPR_ASSERT_IMPLY(a_pop_not_empty, i_pop, o_valid, "queue read while empty")
    `SPR_ASSERT_ALWAYS(a_fill_bound, r_fill <= spr_pkg::QFILL_W'(spr_pkg::QUEUE_DEPTH), "queue fill out of range")

endmodule

/* rtl/core/spr_back.sv */
`include "stream_pattern_removal_stack_defines.svh"

module spr_back #(
    parameter int STACK_DEPTH = spr_pkg::STACK_DEPTH_DEF,
    parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spr_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  spr_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output spr_pkg::t_result o_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = $clog2(MAX_PATTERN + 1);

    spr_pkg::t_state  r_state,     n_state;
    spr_pkg::t_cmd    r_cmd,       n_cmd;
    logic [CW-1:0]    r_count,     n_count;
    logic [CW-1:0]    r_rp,        n_rp;
    logic [CW-1:0]    r_base,      n_base;
    logic [IW-1:0]    r_ridx,      n_ridx;
    logic [IW-1:0]    r_cidx,      n_cidx;
    logic             r_cvalid,    n_cvalid;
    spr_pkg::t_result r_res,       n_res;
    spr_pkg::t_result r_out,       n_out;
    logic             r_out_valid, n_out_valid;

    logic [spr_pkg::BYTE_W-1:0] r_stack_mem [STACK_DEPTH];
    logic [spr_pkg::BYTE_W-1:0] r_rd_data;

    logic [IW-1:0]              w_len;
    logic [CW-1:0]              w_count_inc;
    logic [CW-1:0]              w_rp_inc;
    logic [CW-1:0]              w_match_addr;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_wr_addr;
    logic                       w_mem_we;
    logic [spr_pkg::BYTE_W-1:0] w_pat_char;

    // Clamp the configured pattern length into 1..MAX_PATTERN
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_len = IW'(1);
        end else if (i_cfg.pattern_length > spr_pkg::PLEN_W'(MAX_PATTERN)) begin
            w_len = IW'(MAX_PATTERN);
        end else begin
            w_len = IW'(i_cfg.pattern_length);
        end
    end

    assign w_count_inc  = r_count + CW'(1);
    assign w_rp_inc     = r_rp + CW'(1);
    assign w_match_addr = r_base + CW'(r_ridx);
    assign w_rd_addr    = (r_state == spr_pkg::S_MATCH) ? w_match_addr[AW-1:0] : r_rp[AW-1:0];
    assign w_wr_addr    = r_count[AW-1:0];
    assign w_pat_char   = i_cfg.pattern_bytes[spr_pkg::BYTE_W*r_cidx +: spr_pkg::BYTE_W];

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer: next state, stack pointers and result fields
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_rp        = r_rp;
        n_base      = r_base;
        n_ridx      = r_ridx;
        n_cidx      = r_cidx;
        n_cvalid    = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;

        // Drop the output once it has been transferred
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            spr_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_res   = '0;
                    unique case (i_q_cmd.op)
                        spr_pkg::OP_PUSH:  n_state = spr_pkg::S_PUSH;
                        spr_pkg::OP_READ:  n_state = spr_pkg::S_RDADDR;
                        spr_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_rp    = '0;
                            n_state = spr_pkg::S_DONE;
                        end
                        default:           n_state = spr_pkg::S_DONE;
                    endcase
                end
            end
            spr_pkg::S_PUSH: begin
                if (r_count >= CW'(STACK_DEPTH)) begin
                    n_res.overflow = 1'b1;
                    n_state        = spr_pkg::S_DONE;
                end else begin
                    w_mem_we = 1'b1;
                    n_count  = w_count_inc;
                    if (w_count_inc >= CW'(w_len)) begin
                        n_base  = w_count_inc - CW'(w_len);
                        n_ridx  = '0;
                        n_state = spr_pkg::S_MATCH;
                    end else begin
                        n_state = spr_pkg::S_DONE;
                    end
                end
            end
            spr_pkg::S_MATCH: begin
                // Issue one stack read a cycle, compare each in the cycle after its read
                if (r_ridx < w_len) begin
                    n_ridx   = r_ridx + IW'(1);
                    n_cidx   = r_ridx;
                    n_cvalid = 1'b1;
                end
                if (r_cvalid) begin
                    if (r_rd_data != w_pat_char) begin
                        n_state = spr_pkg::S_DONE;
                    end else if (r_cidx == w_len - IW'(1)) begin
                        n_count       = r_base;
                        n_res.removed = 1'b1;
                        if (r_rp > r_base) begin
                            n_rp = r_base;
                        end
                        n_state = spr_pkg::S_DONE;
                    end
                end
            end
            spr_pkg::S_RDADDR: begin
                if (r_rp < r_count) begin
                    n_state = spr_pkg::S_RDDATA;
                end else begin
                    n_res.read_empty = 1'b1;
                    n_state          = spr_pkg::S_DONE;
                end
            end
            spr_pkg::S_RDDATA: begin
                n_res.out_byte  = r_rd_data;
                n_res.read_last = (w_rp_inc == r_count);
                n_rp            = w_rp_inc;
                n_state         = spr_pkg::S_DONE;
            end
            spr_pkg::S_DONE: begin
                // Load the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out            = r_res;
                    n_out.kept_count = spr_pkg::KEPT_W'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = spr_pkg::S_IDLE;
                end
            end
            default: n_state = spr_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rp        <= '0;
            r_cvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rp        <= n_rp;
            r_cvalid    <= n_cvalid;
            r_out_valid <= n_out_valid;
        end
        r_cmd  <= n_cmd;
        r_base <= n_base;
        r_ridx <= n_ridx;
        r_cidx <= n_cidx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Stack memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_stack_mem[w_wr_addr] <= r_cmd.text_byte;
        end
        r_rd_data <= r_stack_mem[w_rd_addr];
    end

    `SPR_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `SPR_ASSERT_ALWAYS(a_rp_bound, r_rp <= r_count, "read pointer beyond stack top")
    `SPR_ASSERT_IMPLY(a_removed_clean, r_out_valid && r_out.removed, !r_out.overflow && !r_out.read_empty, "removal flagged with overflow or empty read")

endmodule

/* sim/stream_pattern_removal_stack_tb.sv */
`timescale 1ns / 100ps

module stream_pattern_removal_stack_tb
    import spr_pkg::*;
();

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 20;

    // Shadow of the byte stack: predicts one result per accepted command
    class removal_tracker;
        logic [BYTE_W-1:0] text_mem [DEPTH];
        int unsigned       kept;
        int unsigned       rd_pos;
        logic [PAT_W-1:0]  pattern;
        logic [PLEN_W-1:0] pat_len;
        t_result           pending [$];
        int unsigned       mismatches;
        int unsigned       pushes, removals, overflows, reads, empties, clears, cfg_writes;

        function new();
            kept       = 0;
            rd_pos     = 0;
            pattern    = '0;
            pat_len    = PLEN_W'(1);
            mismatches = 0;
            pushes     = 0;
            removals   = 0;
            overflows  = 0;
            reads      = 0;
            empties    = 0;
            clears     = 0;
            cfg_writes = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] data);
            cfg_writes++;
            if (idx == CFG_PATTERN_BYTES) begin
                pattern = data;
            end else if (idx == CFG_PATTERN_LENGTH) begin
                pat_len = data[PLEN_W-1:0];
            end
        endfunction

        function void take_command(t_op op, logic [BYTE_W-1:0] ch);
            t_result     exp;
            int unsigned n;
            bit          hit;
            exp = '0;
            case (op)
                OP_PUSH: begin
                    pushes++;
                    if (kept >= DEPTH) begin
                        // full: drop the byte, skip the pattern check
                        exp.overflow = 1'b1;
                        overflows++;
                    end else begin
                        n = (pat_len == 0) ? 1 :
                            ((pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len);
                        text_mem[kept] = ch;
                        kept++;
                        hit = (kept >= n);
                        for (int unsigned i = 0; i < n; i++) begin
                            if (hit && text_mem[kept - n + i] !== pattern[8*i +: 8])
                                hit = 1'b0;
                        end
                        if (hit) begin
                            kept -= n;
                            exp.removed = 1'b1;
                            removals++;
                            if (rd_pos > kept)
                                rd_pos = kept;
                        end
                    end
                end
                OP_READ: begin
                    reads++;
                    if (rd_pos < kept) begin
                        exp.out_byte  = text_mem[rd_pos];
                        rd_pos++;
                        exp.read_last = (rd_pos == kept);
                    end else begin
                        exp.read_empty = 1'b1;
                        empties++;
                    end
                end
                OP_CLEAR: begin
                    clears++;
                    kept   = 0;
                    rd_pos = 0;
                end
                default: ;
            endcase
            exp.kept_count = KEPT_W'(kept);
            pending.insert(pending.size(), exp);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("result with no command outstanding (kept_count %0d)", got.kept_count);
                mismatches++;
                return;
            end
            exp = pending.pop_front();
            compare("out_byte",   exp.out_byte,   got.out_byte);
            compare("kept_count", exp.kept_count, got.kept_count);
            compare("removed",    exp.removed,    got.removed);
            compare("read_last",  exp.read_last,  got.read_last);
            compare("read_empty", exp.read_empty, got.read_empty);
            compare("overflow",   exp.overflow,   got.overflow);
        endfunction
    endclass

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PAT_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OPCODE_W-1:0]  i_opcode;
    logic [BYTE_W-1:0]    i_text_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_out_byte;
    logic [KEPT_W-1:0]    o_kept_count;
    logic                 o_removed;
    logic                 o_read_last;
    logic                 o_read_empty;
    logic                 o_overflow;

    removal_tracker tracker = new();
    int unsigned    items_sent = 0;
    bit             steady = 1'b0;

    stream_pattern_removal_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_text_byte (i_text_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_kept_count(o_kept_count),
        .o_removed   (o_removed),
        .o_read_last (o_read_last),
        .o_read_empty(o_read_empty),
        .o_overflow  (o_overflow)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one command and hold it until the transfer completes
    task automatic send_command(input t_op op, input logic [BYTE_W-1:0] ch);
        int unsigned gap;
        i_opcode    <= op;
        i_text_byte <= ch;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_command(op, ch);
        items_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PAT_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One setting of the pattern, then a mix weighted towards real occurrences
    task automatic run_phase(input logic [PLEN_W-1:0] len_reg,
                             input logic [PAT_W-1:0] pat, input int unsigned budget);
        int unsigned n, stop_at, r, cut, idx, drain;
        write_register(CFG_PATTERN_BYTES, pat);
        write_register(CFG_PATTERN_LENGTH, PAT_W'(len_reg));
        n = (len_reg == 0) ? 1 : ((len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len_reg);
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                idx = $urandom_range(0, n - 1);
                send_command(OP_PUSH, 8'(pat >> (8 * idx)));
            end else if (r < 58) begin
                // whole occurrence, now and then broken off early
                cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
                for (int unsigned i = 0; i < cut; i++)
                    send_command(OP_PUSH, 8'(pat >> (8 * i)));
            end else if (r < 70) begin
                send_command(OP_PUSH, 8'($urandom));
            end else if (r < 84) begin
                send_command(OP_READ, 8'($urandom));
            end else if (r < 88) begin
                // read out to the end and two past it
                drain = tracker.kept - tracker.rd_pos + 2;
                if (drain > 40)
                    drain = 40;
                repeat (drain) send_command(OP_READ, 8'($urandom));
            end else if (r < 93) begin
                send_command(OP_CLEAR, 8'($urandom));
            end else begin
                send_command(OP_NOP, 8'($urandom));
            end
        end
    endtask

    // Receiver back-pressure
    initial begin
        int unsigned hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            hold = pick_gap();
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 5)) @(posedge i_clk);
        end
    end

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.out_byte   = o_out_byte;
            seen.kept_count = o_kept_count;
            seen.removed    = o_removed;
            seen.read_last  = o_read_last;
            seen.read_empty = o_read_empty;
            seen.overflow   = o_overflow;
            tracker.check_result(seen);
        end
    end

    initial begin
        logic [PAT_W-1:0]  pat;
        logic [PLEN_W-1:0] len;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PATTERN_BYTES;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_PUSH;
        i_text_byte <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: single-character pattern of 0x00
        send_command(OP_PUSH, 8'hFF);
        send_command(OP_PUSH, 8'h00);
        send_command(OP_READ, 8'h00);
        send_command(OP_READ, 8'hFF);
        send_command(OP_NOP, 8'h5A);
        send_command(OP_CLEAR, 8'hA5);
        send_command(OP_READ, 8'h00);

        // All-ones pattern; a length above the cap acts as eight
        write_register(CFG_PATTERN_BYTES, '1);
        write_register(CFG_PATTERN_LENGTH, PAT_W'(15));
        repeat (8) send_command(OP_PUSH, 8'hFF);

        // Zero length acts as one
        write_register(CFG_PATTERN_BYTES, 64'h6261);
        write_register(CFG_PATTERN_LENGTH, '0);
        send_command(OP_PUSH, 8'h61);

        // Two characters: pull the read pointer down, then nested removals
        write_register(CFG_PATTERN_LENGTH, PAT_W'(2));
        send_command(OP_PUSH, 8'h78);
        send_command(OP_PUSH, 8'h79);
        send_command(OP_PUSH, 8'h61);
        repeat (3) send_command(OP_READ, 8'h00);
        send_command(OP_PUSH, 8'h62);
        send_command(OP_READ, 8'h00);
        send_command(OP_PUSH, 8'h61);
        send_command(OP_PUSH, 8'h61);
        send_command(OP_PUSH, 8'h62);
        send_command(OP_PUSH, 8'h62);
        send_command(OP_READ, 8'h00);

        // Fill the stack with bytes that never match, then push into a full stack
        write_register(CFG_PATTERN_BYTES, '0);
        write_register(CFG_PATTERN_LENGTH, PAT_W'(1));
        send_command(OP_CLEAR, 8'($urandom));
        for (int k = 0; k < DEPTH; k++) begin
            send_command(OP_PUSH, 8'($urandom_range(1, 255)));
            if (k == DEPTH / 2)
                wait_drained();
        end
        send_command(OP_PUSH, 8'h00);
        send_command(OP_PUSH, 8'hFF);
        repeat (6) send_command(OP_READ, 8'($urandom));
        send_command(OP_PUSH, 8'h00);
        send_command(OP_CLEAR, 8'($urandom));
        send_command(OP_READ, 8'($urandom));

        // Random phases over every length, the out-of-range codes among them
        for (int ph = 0; ph < 12; ph++) begin
            steady = (ph % 4 == 2);
            case (ph % 3)
                0: pat = {$urandom, $urandom};
                1: for (int j = 0; j < 8; j++)
                       pat[8*j +: 8] = 8'h61 + 8'($urandom_range(0, 2));
                default: pat = {8{8'($urandom_range(0, 255))}};
            endcase
            if (ph < 8)
                len = PLEN_W'(ph + 1);
            else if (ph == 8)
                len = '0;
            else if (ph == 9)
                len = PLEN_W'(15);
            else
                len = PLEN_W'($urandom_range(0, 15));
            run_phase(len, pat, 55);
        end
        steady = 1'b0;

        wait_drained();
        $display("Covered %0d pushes: %0d pattern removals, %0d dropped on a full stack.",
                 tracker.pushes, tracker.removals, tracker.overflows);
        $display("Also %0d reads (%0d past the end), %0d clears, %0d register writes.",
                 tracker.reads, tracker.empties, tracker.clears, tracker.cfg_writes);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
